>>> rtl/obbcp_pkg.sv
`timescale 1ns / 1ps

package obbcp_pkg;

  // default coordinate width (signed Q8.8)
  localparam int COORD_WIDTH_DEF = 16;

  // configuration registers are all this wide
  localparam int REG_W = 48;

  // axis component format: signed Q1.14
  localparam int AXIS_W    = 16;
  localparam int AXIS_FRAC = 14;

  // number of box axes, one cell each
  localparam int NUM_AXES = 3;

  // configuration register index width
  localparam int CFG_IDX_W = 3;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_HALF   = 3'd1,
    REG_AXIS0  = 3'd2,
    REG_AXIS1  = 3'd3,
    REG_AXIS2  = 3'd4
  } cfg_reg_t;

endpackage

>>> rtl/obbcp_cell.sv
`timescale 1ns / 1ps

module obbcp_cell #(
  parameter int COORD_WIDTH = obbcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [obbcp_pkg::AXIS_W-1:0]   ax [3],
  input  logic        [COORD_WIDTH-1:0]         half,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH:0]           in_dir [3],
  input  logic signed [COORD_WIDTH+18:0]        in_acc [3],
  input  logic                                  in_inside,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH:0]           out_dir [3],
  output logic signed [COORD_WIDTH+18:0]        out_acc [3],
  output logic                                  out_inside
);
  import obbcp_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = DW + AXIS_W;
  localparam int SW = COORD_WIDTH + 19;
  localparam logic signed [SW-1:0] RND = SW'(2 ** (AXIS_FRAC - 1));

  // stage 1: offset times axis components
  logic                 v1;
  logic                 rdy1;
  logic signed [MW-1:0] prod1 [3];
  logic signed [DW-1:0] dir1 [3];
  logic signed [SW-1:0] acc1 [3];
  logic                 ins1;

  // stage 2: clamped, rounded distance along the axis
  logic                 v2;
  logic                 rdy2;
  logic signed [DW-1:0] dist2;
  logic signed [DW-1:0] dir2 [3];
  logic signed [SW-1:0] acc2 [3];
  logic                 ins2;

  // stage 3: accumulate axis times distance
  logic                 v3;
  logic                 rdy3;
  logic signed [DW-1:0] dir3 [3];
  logic signed [SW-1:0] acc3 [3];
  logic                 ins3;

  // stage 2 combinational terms
  logic signed [SW-1:0] p0, p1, p2;
  logic signed [SW-1:0] proj;
  logic signed [SW-1:0] lim;
  logic signed [SW-1:0] clamped;
  logic signed [SW-1:0] rounded;
  logic signed [SW-1:0] shifted;
  logic                 clip;
  logic signed [MW-1:0] mul3 [3];

  // ready chain, a stage moves when it is empty or its successor moves
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int k = 0; k < 3; k++) begin
        prod1[k] <= in_dir[k] * ax[k];
        dir1[k]  <= in_dir[k];
        acc1[k]  <= in_acc[k];
      end
      ins1 <= in_inside;
    end
  end

  // projection, clamp against the half-extent, round half up
  assign p0   = SW'(prod1[0]);
  assign p1   = SW'(prod1[1]);
  assign p2   = SW'(prod1[2]);
  assign proj = p0 + p1 + p2;
  assign lim  = SW'({half, {AXIS_FRAC{1'b0}}});

  always_comb begin
    clip    = 1'b0;
    clamped = proj;
    if (proj > lim) begin
      clamped = lim;
      clip    = 1'b1;
    end else if (proj < -lim) begin
      clamped = -lim;
      clip    = 1'b1;
    end
  end

  assign rounded = clamped + RND;
  assign shifted = rounded >>> AXIS_FRAC;

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      dist2 <= shifted[DW-1:0];
      dir2  <= dir1;
      acc2  <= acc1;
      ins2  <= ins1 && !clip;
    end
  end

  // axis times distance
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul3[k] = ax[k] * dist2;
    end
  end

  // stage 3 payload
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int k = 0; k < 3; k++) begin
        acc3[k] <= acc2[k] + SW'(mul3[k]);
      end
      dir3 <= dir2;
      ins3 <= ins2;
    end
  end

  assign out_valid  = v3;
  assign out_dir    = dir3;
  assign out_acc    = acc3;
  assign out_inside = ins3;

endmodule

>>> rtl/obbcp_out.sv
`timescale 1ns / 1ps

module obbcp_out #(
  parameter int COORD_WIDTH = obbcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_WIDTH+18:0] in_acc [3],
  input  logic                           in_inside,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [COORD_WIDTH-1:0]  near [3],
  output logic                           inside_flag
);
  import obbcp_pkg::*;

  localparam int SW = COORD_WIDTH + 19;
  localparam logic signed [SW-1:0] RND = SW'(2 ** (AXIS_FRAC - 1));
  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  logic                          vld;
  logic signed [SW-1:0]          rounded [3];
  logic signed [SW-1:0]          shifted [3];
  logic signed [COORD_WIDTH-1:0] sat [3];

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // round half up to the coordinate grid, then saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rounded[k] = in_acc[k] + RND;
      shifted[k] = rounded[k] >>> AXIS_FRAC;
      if (shifted[k] > SAT_HI) begin
        sat[k] = SAT_HI[COORD_WIDTH-1:0];
      end else if (shifted[k] < SAT_LO) begin
        sat[k] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        sat[k] = shifted[k][COORD_WIDTH-1:0];
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      near        <= sat;
      inside_flag <= in_inside;
    end
  end

endmodule

>>> rtl/obb_closest_point_query.sv
`timescale 1ns / 1ps

// channel   signals                                       direction
// ------    --------------------------------------------  ---------
// point     in_valid, in_ready, point_x/y/z                in
// result    out_valid, out_ready, nearest_x/y/z, inside_res out
// config    cfg_we, cfg_index, cfg_data                    in
//
// one point accepted per cycle unless the output is stalled; the pipeline has
// one offset stage, three axis cells of three stages each and one output register
// every stage has its own valid bit, so bubbles collapse and the block keeps
// taking items while a finished result waits at the output
// synchronous reset clears all valid bits and the box registers to zero
// box registers are read directly by the cells; write them only while idle

module obb_closest_point_query #(
  parameter int COORD_WIDTH = obbcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [obbcp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [obbcp_pkg::REG_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         point_x,
  input  logic signed [COORD_WIDTH-1:0]         point_y,
  input  logic signed [COORD_WIDTH-1:0]         point_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH-1:0]         nearest_x,
  output logic signed [COORD_WIDTH-1:0]         nearest_y,
  output logic signed [COORD_WIDTH-1:0]         nearest_z,
  output logic                                  inside_res
);
  import obbcp_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int SW = COORD_WIDTH + 19;
  localparam int XW = (3 * COORD_WIDTH > REG_W) ? 3 * COORD_WIDTH : REG_W;

  // box registers
  logic [REG_W-1:0] box_center;
  logic [REG_W-1:0] box_half_extent;
  logic [REG_W-1:0] axis_reg [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      box_center      <= '0;
      box_half_extent <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_reg[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER: box_center      <= cfg_data;
        REG_HALF:   box_half_extent <= cfg_data;
        REG_AXIS0:  axis_reg[0]     <= cfg_data;
        REG_AXIS1:  axis_reg[1]     <= cfg_data;
        REG_AXIS2:  axis_reg[2]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // field unpacking, fields above the register read as zero
  logic        [XW-1:0]          center_x;
  logic        [XW-1:0]          half_x;
  logic signed [COORD_WIDTH-1:0] ctr [3];
  logic        [COORD_WIDTH-1:0] half [NUM_AXES];
  logic signed [AXIS_W-1:0]      ax [NUM_AXES][3];
  logic signed [COORD_WIDTH-1:0] pt [3];

  assign center_x = XW'(box_center);
  assign half_x   = XW'(box_half_extent);
  assign pt[0]    = point_x;
  assign pt[1]    = point_y;
  assign pt[2]    = point_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ctr[k]  = center_x[k*COORD_WIDTH +: COORD_WIDTH];
      half[k] = half_x[k*COORD_WIDTH +: COORD_WIDTH];
      for (int i = 0; i < NUM_AXES; i++) begin
        ax[i][k] = axis_reg[i][k*AXIS_W +: AXIS_W];
      end
    end
  end

  // cell chain links
  logic                 chain_valid [NUM_AXES+1];
  logic                 chain_ready [NUM_AXES+1];
  logic signed [DW-1:0] chain_dir [NUM_AXES+1][3];
  logic signed [SW-1:0] chain_acc [NUM_AXES+1][3];
  logic                 chain_inside [NUM_AXES+1];

  // offset stage: point minus centre, accumulator seeded with the centre
  logic v0;
  logic rdy0;

  assign rdy0     = !v0 || chain_ready[0];
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      for (int k = 0; k < 3; k++) begin
        chain_dir[0][k] <= DW'(pt[k]) - DW'(ctr[k]);
        chain_acc[0][k] <= SW'(signed'({ctr[k], {AXIS_FRAC{1'b0}}}));
      end
      chain_inside[0] <= 1'b1;
    end
  end

  assign chain_valid[0] = v0;

  // one cell per box axis
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_cell
    obbcp_cell #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ax         (ax[i]),
      .half       (half[i]),
      .in_valid   (chain_valid[i]),
      .in_ready   (chain_ready[i]),
      .in_dir     (chain_dir[i]),
      .in_acc     (chain_acc[i]),
      .in_inside  (chain_inside[i]),
      .out_valid  (chain_valid[i+1]),
      .out_ready  (chain_ready[i+1]),
      .out_dir    (chain_dir[i+1]),
      .out_acc    (chain_acc[i+1]),
      .out_inside (chain_inside[i+1])
    );
  end

  // rounding, saturation and the output register
  logic signed [COORD_WIDTH-1:0] near [3];

  obbcp_out #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (chain_valid[NUM_AXES]),
    .in_ready    (chain_ready[NUM_AXES]),
    .in_acc      (chain_acc[NUM_AXES]),
    .in_inside   (chain_inside[NUM_AXES]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .near        (near),
    .inside_flag (inside_res)
  );

  assign nearest_x = near[0];
  assign nearest_y = near[1];
  assign nearest_z = near[2];

endmodule

>>> rtl/obbcp_chk.sv
`timescale 1ns / 1ps

module obbcp_chk #(
  parameter int COORD_WIDTH = obbcp_pkg::COORD_WIDTH_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [COORD_WIDTH-1:0]        nearest_x,
  input logic signed [COORD_WIDTH-1:0]        nearest_y,
  input logic signed [COORD_WIDTH-1:0]        nearest_z,
  input logic                                 inside_res
);

  // nothing comes out of the cycle right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item shown right after reset");

  // an empty output register means every stage behind it can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(nearest_x) && $stable(nearest_y)
      && $stable(nearest_z) && $stable(inside_res))
    else $error("result item changed while stalled");

endmodule

bind obb_closest_point_query obbcp_chk #(
  .COORD_WIDTH(COORD_WIDTH)
) u_obbcp_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .nearest_x  (nearest_x),
  .nearest_y  (nearest_y),
  .nearest_z  (nearest_z),
  .inside_res (inside_res)
);

>>> test/tb_obb_closest_point_query.sv
`timescale 1ns / 1ps

module tb_obb_closest_point_query;
  import obbcp_pkg::*;

  localparam int COORD_W = COORD_WIDTH_DEF;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS_PER_SETTING = 56;
  localparam int NUM_BOX_REGS = 5;
  localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint ROUND_HALF = longint'(1) <<< (AXIS_FRAC - 1);
  localparam logic [AXIS_W-1:0] AXIS_UNIT = 16'h4000;
  localparam logic [AXIS_W-1:0] AXIS_DIAG = 16'd11585;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 16'h0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic in_box;
  } nearest_t;

  typedef enum {BOX_ALIGNED, BOX_ROTATED, BOX_EXTREME_HIGH, BOX_EXTREME_LOW, BOX_RANDOM}
    box_style_t;

  // box registers, closest-point prediction and the queue of pending results
  class box_query_board;
    logic [REG_W-1:0] center_reg;
    logic [REG_W-1:0] half_reg;
    logic [REG_W-1:0] axis_reg [NUM_AXES];
    nearest_t pending_nearest [$];
    int mismatches;

    function new();
      center_reg = '0;
      half_reg = '0;
      foreach (axis_reg[i]) axis_reg[i] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
      case (idx)
        REG_CENTER: center_reg = data;
        REG_HALF:   half_reg = data;
        REG_AXIS0:  axis_reg[0] = data;
        REG_AXIS1:  axis_reg[1] = data;
        REG_AXIS2:  axis_reg[2] = data;
        default: ;
      endcase
    endfunction

    function nearest_t nearest_on_box(logic signed [COORD_W-1:0] px, py, pz);
      logic signed [COORD_W-1:0] pt [3];
      logic signed [COORD_W-1:0] near [3];
      longint ctr [3];
      longint offs [3];
      longint acc [3];
      longint ax [3];
      longint proj, lim, step_dist, sum;
      logic in_box;
      pt[0] = px;
      pt[1] = py;
      pt[2] = pz;
      in_box = 1'b1;
      // offset from the centre, accumulator starts at the centre
      for (int k = 0; k < 3; k++) begin
        ctr[k] = longint'($signed(center_reg[k*COORD_W +: COORD_W]));
        offs[k] = longint'(pt[k]) - ctr[k];
        acc[k] = ctr[k] <<< AXIS_FRAC;
      end
      // exact projection, clamp to the half-extent, round, add back along the axis
      for (int i = 0; i < NUM_AXES; i++) begin
        proj = 0;
        for (int k = 0; k < 3; k++) begin
          ax[k] = longint'($signed(axis_reg[i][k*AXIS_W +: AXIS_W]));
          proj += offs[k] * ax[k];
        end
        lim = longint'(half_reg[i*COORD_W +: COORD_W]) <<< AXIS_FRAC;
        if (proj > lim) begin
          proj = lim;
          in_box = 1'b0;
        end else if (proj < -lim) begin
          proj = -lim;
          in_box = 1'b0;
        end
        step_dist = (proj + ROUND_HALF) >>> AXIS_FRAC;
        for (int k = 0; k < 3; k++) acc[k] += ax[k] * step_dist;
      end
      // round half up and saturate each coordinate
      for (int k = 0; k < 3; k++) begin
        sum = (acc[k] + ROUND_HALF) >>> AXIS_FRAC;
        if (sum > COORD_MAX) sum = COORD_MAX;
        if (sum < COORD_MIN) sum = COORD_MIN;
        near[k] = sum[COORD_W-1:0];
      end
      return '{near[0], near[1], near[2], in_box};
    endfunction

    function void note_point(logic signed [COORD_W-1:0] px, py, pz);
      pending_nearest.push_back(nearest_on_box(px, py, pz));
    endfunction

    function void check_result(nearest_t got);
      nearest_t want;
      if (pending_nearest.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: %0d %0d %0d in_box %0b",
                   got.x, got.y, got.z, got.in_box);
        return;
      end
      want = pending_nearest.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"nearest mismatch: expected %0d %0d %0d in_box %0b, ",
                    "got %0d %0d %0d in_box %0b"},
                   want.x, want.y, want.z, want.in_box, got.x, got.y, got.z, got.in_box);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] nearest_x;
  logic signed [COORD_W-1:0] nearest_y;
  logic signed [COORD_W-1:0] nearest_z;
  logic inside_res;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  nearest_t seen_nearest;
  box_query_board board = new();
  box_style_t schedule [8] = '{BOX_ALIGNED, BOX_ROTATED, BOX_EXTREME_HIGH, BOX_RANDOM,
                               BOX_EXTREME_LOW, BOX_ALIGNED, BOX_ROTATED, BOX_RANDOM};

  obb_closest_point_query #(
    .COORD_WIDTH(COORD_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .nearest_x(nearest_x),
    .nearest_y(nearest_y),
    .nearest_z(nearest_z),
    .inside_res(inside_res)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_point(point_x, point_y, point_z);
      if (out_valid && out_ready) begin
        seen_nearest = '{nearest_x, nearest_y, nearest_z, inside_res};
        board.check_result(seen_nearest);
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_obb_closest_point_query: errors");
      $finish;
    end
  end

  // offer one query point, optionally holding off until the block has drained
  task automatic query_point(input logic [COORD_W-1:0] x, y, z, input bit hold_until_empty);
    if (hold_until_empty || $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      if (hold_until_empty)
        while (board.pending_nearest.size() != 0) @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and let every pending result come out
  task automatic wait_box_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_nearest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  function automatic logic [REG_W-1:0] rand_reg();
    return REG_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [COORD_W-1:0] small_coord();
    return COORD_W'(int'($urandom_range(16'h1000)) - 16'h0800);
  endfunction

  // mostly points around the box, some anywhere
  function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
    if ($urandom_range(9) < 7)
      return COORD_W'(int'($signed(c)) + int'($urandom_range(16'h2800)) - 16'h1400);
    return COORD_W'($urandom_range(16'hFFFF));
  endfunction

  // write the whole box, plus a stray write to an unmapped index
  task automatic load_box(input logic [REG_W-1:0] ctr, half, a0, a1, a2);
    write_reg(REG_CENTER, ctr);
    write_reg(REG_HALF, half);
    write_reg(REG_AXIS0, a0);
    write_reg(REG_AXIS1, a1);
    write_reg(REG_AXIS2, a2);
    write_reg(CFG_IDX_W'($urandom_range(7, NUM_BOX_REGS)), rand_reg());
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // zero axes after reset: output is the centre and always in the box
    query_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
    query_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    query_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    wait_box_idle();

    // aligned box: centre, faces exactly on and just past
    load_box({16'h0000, 16'hFF00, 16'h0100}, {16'h0080, 16'h0100, 16'h0200},
             {AXIS_NONE, AXIS_NONE, AXIS_UNIT}, {AXIS_NONE, AXIS_UNIT, AXIS_NONE},
             {AXIS_UNIT, AXIS_NONE, AXIS_NONE});
    query_point(16'h0100, 16'hFF00, 16'h0000, 1'b0);
    query_point(16'h0300, 16'hFF00, 16'h0000, 1'b0);
    query_point(16'h0301, 16'hFF00, 16'h0000, 1'b0);
    query_point(16'hFF00, 16'hFF00, 16'h0000, 1'b0);
    query_point(16'hFEFF, 16'hFF00, 16'h0000, 1'b0);
    query_point(16'h0100, 16'h0000, 16'h0000, 1'b0);
    query_point(16'h0100, 16'hFF00, 16'hFF7F, 1'b0);
    query_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    query_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    query_point(16'h7FFF, 16'h8000, 16'h0001, 1'b0);
    wait_box_idle();

    // rotated box: fractional projections exercise the rounding
    load_box({16'h0000, 16'h0000, 16'h0000}, {16'h0100, 16'h0100, 16'h0100},
             {AXIS_NONE, AXIS_DIAG, AXIS_DIAG}, {AXIS_NONE, AXIS_DIAG, 16'(-AXIS_DIAG)},
             {AXIS_UNIT, AXIS_NONE, AXIS_NONE});
    query_point(16'h0101, 16'h0003, 16'h0000, 1'b0);
    query_point(16'h0500, 16'hFB00, 16'h0040, 1'b0);
    query_point(16'h0080, 16'h0080, 16'h0080, 1'b0);
    wait_box_idle();

    // non-unit axes at the top of the range: outputs saturate
    load_box({3{16'h7FFF}}, {3{16'hFFFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    query_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    query_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    query_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
    wait_box_idle();

    // most negative everything, zero extents
    load_box({3{16'h8000}}, {3{16'h0000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    query_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    query_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    query_point(16'h1234, 16'hEDCB, 16'h0F0F, 1'b0);

    // random queries over several boxes and handshake patterns
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int s = 0; s < 2; s++) begin
        wait_box_idle();
        case (schedule[phase*2 + s])
          BOX_ALIGNED:
            load_box({small_coord(), small_coord(), small_coord()},
                     {16'($urandom_range(16'h0800)), 16'($urandom_range(16'h0800)),
                      16'($urandom_range(16'h0800))},
                     {AXIS_NONE, AXIS_NONE, AXIS_UNIT}, {AXIS_NONE, AXIS_UNIT, AXIS_NONE},
                     {AXIS_UNIT, AXIS_NONE, AXIS_NONE});
          BOX_ROTATED:
            load_box({small_coord(), small_coord(), small_coord()},
                     {16'($urandom_range(16'h1000)), 16'($urandom_range(16'h1000)),
                      16'($urandom_range(16'h1000))},
                     {AXIS_NONE, AXIS_DIAG, AXIS_DIAG},
                     {AXIS_NONE, AXIS_DIAG, 16'(-AXIS_DIAG)},
                     {AXIS_UNIT, AXIS_NONE, AXIS_NONE});
          BOX_EXTREME_HIGH:
            load_box({3{16'h7FFF}}, {3{16'hFFFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                     {3{16'h7FFF}});
          BOX_EXTREME_LOW:
            load_box({3{16'h8000}}, {3{16'h0000}}, {3{16'h8000}}, {3{16'h8000}},
                     {3{16'h8000}});
          default:
            load_box(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
        endcase
        for (int n = 0; n < ITEMS_PER_SETTING; n++)
          query_point(near_coord(board.center_reg[0 +: COORD_W]),
                      near_coord(board.center_reg[COORD_W +: COORD_W]),
                      near_coord(board.center_reg[2*COORD_W +: COORD_W]),
                      (s == 0 && n == ITEMS_PER_SETTING / 2));
      end
    end

    wait_box_idle();
    if (board.mismatches == 0 && board.pending_nearest.size() == 0) begin
      $display("tb_obb_closest_point_query: clean");
    end else begin
      $display("tb_obb_closest_point_query: errors");
    end
    $finish;
  end

endmodule

>>> obb_closest_point_query.f
rtl/obbcp_pkg.sv
rtl/obbcp_cell.sv
rtl/obbcp_out.sv
rtl/obb_closest_point_query.sv
rtl/obbcp_chk.sv
test/tb_obb_closest_point_query.sv
